// ----- hw/rtl/mmmt_pkg.sv -----
// Package for the min/max/mean tracker: request codes, sequencer states and
// the field widths of the tracker. No dependencies.
`timescale 1ns / 1ps
package mmmt_pkg;
   localparam int unsigned ValueWidth = 32;
   localparam int unsigned MeanWidth  = 48;
   localparam int unsigned CountWidth = 7;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_QUERY  = 2'd2,
      REQ_SPARE  = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RESCAN,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;
endpackage

// ----- hw/rtl/mmmt_divider.sv -----
// Restoring divider, one quotient bit per cycle, for the mean.
// No dependencies.
`timescale 1ns / 1ps
module mmmt_divider #(
   parameter int unsigned NumWidth = 54,
   parameter int unsigned DenWidth = 13
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NumWidth-1:0] numerator,
   input  logic [DenWidth-1:0] denominator,
   output logic                done,
   output logic [NumWidth-1:0] quotient
);
   localparam int unsigned CntWidth = $clog2(NumWidth + 1);

   logic [NumWidth-1:0] quo_ff, quo_in;
   logic [DenWidth:0]   rem_ff, rem_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [DenWidth:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[DenWidth-1:0], quo_ff[NumWidth-1]};
      if (start) begin
         quo_in  = numerator;
         rem_in  = '0;
         cnt_in  = CntWidth'(NumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, denominator}) begin
            rem_in = trial - {1'b0, denominator};
            quo_in = {quo_ff[NumWidth-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CntWidth'(1);
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = busy_ff && (cnt_ff == CntWidth'(1));
   assign quotient = quo_in;
endmodule

// ----- hw/rtl/multiset_min_max_mean_tracker.sv -----
// Top level of the min/max/mean tracker: slot memory, scan sequencer and
// mean divider. Depends on mmmt_pkg and mmmt_divider.
// Every request ends with the serial division of the mean, skipped when the set
// is empty; a removal adds a search of the slots and a rescan of all slots
// when a removed extreme is lost. One request at a time, the next one accepted
// in the cycle after the response is taken. Reset clears valid bits.
`timescale 1ns / 1ps
module multiset_min_max_mean_tracker #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // [1:0] req_type, [33:2] value
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // is_empty, min, max, mean, count, dropped
);
   localparam int unsigned IdxWidth = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CntWidth = $clog2(CAPACITY + 1);
   localparam int unsigned SumWidth = mmmt_pkg::ValueWidth + CntWidth;
   localparam int unsigned NumWidth = SumWidth + 16;

   logic signed [31:0] mem [CAPACITY];
   logic [CAPACITY-1:0] valid_ff, valid_in;
   mmmt_pkg::state_type state_ff, state_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic signed [SumWidth-1:0] sum_ff, sum_in;
   logic signed [31:0] min_ff, min_in, max_ff, max_in;
   logic [1:0] op_ff, op_in;
   logic signed [31:0] val_ff, val_in;
   logic [CntWidth-1:0] idx_ff, idx_in;
   logic [IdxWidth-1:0] rd_idx_ff;
   logic rd_vld_ff, rd_vld_in;
   logic signed [31:0] rd_data_ff;
   logic seen_ff, seen_in, done_ff, done_in, drop_ff, drop_in;
   logic wr_en;
   logic [IdxWidth-1:0] wr_idx;
   logic free_found;
   logic [IdxWidth-1:0] free_idx;
   logic div_start, div_done;
   logic [NumWidth-1:0] div_num, div_q;
   logic [NumWidth-1:0] mag;
   logic signed [47:0] mean_ff, mean_in;
   logic signed [31:0] rmin, rmax;

   mmmt_divider #(.NumWidth(NumWidth), .DenWidth(CntWidth)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numerator(div_num),
      .denominator(count_ff), .done(div_done), .quotient(div_q)
   );

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IdxWidth'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= val_ff;
      end
      rd_data_ff <= mem[idx_ff[IdxWidth-1:0]];
      rd_idx_ff  <= idx_ff[IdxWidth-1:0];
   end

   assign mag = sum_ff[SumWidth-1] ? NumWidth'(-sum_ff) << 16
                                   : NumWidth'(sum_ff) << 16;
   assign div_num = mag;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mmmt_pkg::ST_IDLE:
            if (req_tvalid) begin
               state_in = (req_tdata[1:0] == mmmt_pkg::REQ_REMOVE)
                  ? mmmt_pkg::ST_SEARCH : mmmt_pkg::ST_DIVIDE;
            end
         mmmt_pkg::ST_SEARCH:
            if (done_ff) begin
               state_in = mmmt_pkg::ST_DIVIDE;
            end else if (rd_vld_ff && valid_ff[rd_idx_ff] && rd_data_ff == val_ff) begin
               state_in = (count_ff != CntWidth'(1) &&
                           (val_ff == min_ff || val_ff == max_ff))
                  ? mmmt_pkg::ST_RESCAN : mmmt_pkg::ST_DIVIDE;
            end else if (idx_ff == CntWidth'(CAPACITY) && rd_vld_ff == 1'b0) begin
               state_in = mmmt_pkg::ST_DIVIDE;
            end
         mmmt_pkg::ST_RESCAN:
            if (done_ff) begin
               state_in = mmmt_pkg::ST_DIVIDE;
            end
         mmmt_pkg::ST_DIVIDE:
            if ((count_ff == '0 && op_ff != mmmt_pkg::REQ_INSERT) || div_done) begin
               state_in = mmmt_pkg::ST_OUTPUT;
            end
         mmmt_pkg::ST_OUTPUT:
            if (rsp_tready) begin
               state_in = mmmt_pkg::ST_IDLE;
            end
         default: state_in = mmmt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff; count_in = count_ff; sum_in = sum_ff;
      min_in = min_ff; max_in = max_ff; op_in = op_ff; val_in = val_ff;
      idx_in = idx_ff; rd_vld_in = 1'b0; seen_in = seen_ff; done_in = 1'b0;
      drop_in = drop_ff; mean_in = mean_ff; wr_en = 1'b0; wr_idx = free_idx;
      div_start = 1'b0;
      rmin = (!seen_ff || rd_data_ff < min_ff) ? rd_data_ff : min_ff;
      rmax = (!seen_ff || rd_data_ff > max_ff) ? rd_data_ff : max_ff;
      unique case (state_ff)
         mmmt_pkg::ST_IDLE:
            if (req_tvalid) begin
               op_in   = (req_tdata[1:0] == mmmt_pkg::REQ_SPARE)
                  ? mmmt_pkg::REQ_QUERY : req_tdata[1:0];
               val_in  = req_tdata[33:2];
               idx_in  = '0;
               drop_in = 1'b0;
            end
         mmmt_pkg::ST_SEARCH: begin
            if (idx_ff != CntWidth'(CAPACITY)) begin
               idx_in    = idx_ff + CntWidth'(1);
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff && valid_ff[rd_idx_ff] && rd_data_ff == val_ff) begin
               valid_in[rd_idx_ff] = 1'b0;
               count_in = count_ff - CntWidth'(1);
               sum_in   = sum_ff - SumWidth'(val_ff);
               idx_in   = '0;
               seen_in  = 1'b0;
               rd_vld_in = 1'b0;
            end
         end
         mmmt_pkg::ST_RESCAN: begin
            if (idx_ff != CntWidth'(CAPACITY)) begin
               idx_in    = idx_ff + CntWidth'(1);
               rd_vld_in = 1'b1;
            end else if (!rd_vld_ff) begin
               done_in = 1'b1;
            end
            if (rd_vld_ff && valid_ff[rd_idx_ff]) begin
               min_in  = rmin;
               max_in  = rmax;
               seen_in = 1'b1;
            end
         end
         mmmt_pkg::ST_DIVIDE: begin
            if (op_ff == mmmt_pkg::REQ_INSERT) begin
               op_in = mmmt_pkg::REQ_QUERY;
               if (free_found) begin
                  wr_en = 1'b1;
                  valid_in[free_idx] = 1'b1;
                  count_in = count_ff + CntWidth'(1);
                  sum_in   = sum_ff + SumWidth'(val_ff);
                  if (count_ff == '0) begin
                     min_in = val_ff; max_in = val_ff;
                  end else begin
                     if (val_ff > max_ff) max_in = val_ff;
                     if (val_ff < min_ff) min_in = val_ff;
                  end
               end else begin
                  drop_in = 1'b1;
               end
            end else begin
               op_in = mmmt_pkg::REQ_SPARE;
               if (op_ff != mmmt_pkg::REQ_SPARE && count_ff != '0) begin
                  div_start = 1'b1;
               end
               if (div_done) begin
                  mean_in = sum_ff[SumWidth-1] ? 48'(-div_q) : 48'(div_q);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mmmt_pkg::ST_IDLE;
         valid_ff <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
         rd_vld_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         rd_vld_ff <= rd_vld_in;
         done_ff  <= done_in;
      end
      op_ff   <= op_in;
      val_ff  <= val_in;
      idx_ff  <= idx_in;
      seen_ff <= seen_in;
      drop_ff <= drop_in;
      mean_ff <= mean_in;
   end

   assign req_tready = (state_ff == mmmt_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == mmmt_pkg::ST_OUTPUT);
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[0] = (count_ff == '0);
      if (count_ff != '0) begin
         rsp_tdata[32:1]   = min_ff;
         rsp_tdata[64:33]  = max_ff;
         rsp_tdata[112:65] = mean_ff;
      end
      rsp_tdata[119:113] = 7'(count_ff);
      rsp_tdata[120]     = drop_ff;
   end
endmodule
